// ===== rtl/acl_pkg.sv =====
// Shared types and constants for the request ACL rule matcher.
// Used by the rule cell, the top level and the port checker; no dependencies.
package acl_pkg;

   localparam int WORD_W         = 64;
   localparam int WORDS_PER_RULE = 8;
   localparam int WORD_SEL_W     = 3;
   localparam int WORD_ADDR_W    = 7;
   localparam int RULES_W        = 5;
   localparam int HIT_IDX_W      = 4;

   // stream widths
   localparam int REQ_TDATA_W = 312;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 8;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_RULES_IDX = 1'b0;

   // item commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   // request formats
   localparam logic [1:0] FMT_NET    = 2'd0;
   localparam logic [1:0] FMT_SERIAL = 2'd1;

   // address kinds
   localparam logic [1:0] ADDR_V4 = 2'd0;
   localparam logic [1:0] ADDR_V6 = 2'd1;

   // word numbers within a rule
   localparam logic [WORD_SEL_W-1:0] W_FLAGS     = 3'd0;
   localparam logic [WORD_SEL_W-1:0] W_REG_RANGE = 3'd1;
   localparam logic [WORD_SEL_W-1:0] W_ADDR_HI   = 3'd2;
   localparam logic [WORD_SEL_W-1:0] W_ADDR_LO   = 3'd3;
   localparam logic [WORD_SEL_W-1:0] W_MASK_HI   = 3'd4;
   localparam logic [WORD_SEL_W-1:0] W_MASK_LO   = 3'd5;
   localparam logic [WORD_SEL_W-1:0] W_SERIAL    = 3'd6;

   localparam logic [7:0]  ASTERISK     = 8'h2A;
   localparam logic [31:0] V4_MAP_UPPER = 32'h0000_FFFF;

   typedef struct packed {
      logic                   cmd;
      logic [WORD_ADDR_W-1:0] word_addr;
      logic [WORD_W-1:0]      word_data;
      logic [1:0]             fmt;
      logic [1:0]             addr_kind;
      logic [63:0]            addr_high;
      logic [63:0]            addr_low;
      logic [15:0]            port;
      logic [7:0]             unit_id;
      logic [7:0]             func_code;
      logic [15:0]            reg_addr;
      logic [63:0]            serial_name;
   } item_type;

   // one slot of the cell chain: the word plus the verdict so far
   typedef struct packed {
      logic                 valid;
      item_type             item;
      logic                 hit;
      logic [HIT_IDX_W-1:0] hit_idx;
      logic                 applicable;
   } chain_type;

endpackage

// ===== rtl/request_acl_rule_matcher.sv =====
// An accepted word passes each rule cell's chain register in turn, then the result register, to rsp_tvalid.
// Throughput: one word per cycle; each word steps through one rule cell per cycle.
// A stalled result holds the whole cell chain until rsp_tready is seen.
// Reset clears the chain's valid bits, the result valid bit and rules_in_use;
// rule words are not cleared and must be written before a check reads them.
module request_acl_rule_matcher #(
   parameter int MAX_RULES         = 16,
   parameter int SERIAL_NAME_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: word_addr, word_data, req_addr_high, req_addr_low, req_port,
   //        req_unit_id, req_function, req_register, req_serial_name, pad
   input  logic [acl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: cmd, req_format, req_addr_kind
   input  logic [acl_pkg::REQ_TUSER_W-1:0] req_tuser,
   // result words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: allowed, rule_hit, hit_index, format_error, pad
   output logic [acl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [acl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [acl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [acl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import acl_pkg::*;

   logic [RULES_W-1:0]     rules_ff;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;
   logic                   advance;
   chain_type              chain_w [MAX_RULES+1];
   chain_type              last;
   logic                   allowed;
   logic                   rule_hit;
   logic [HIT_IDX_W-1:0]   hit_index;
   logic                   format_error;

   // register port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rules_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1] == CSR_RULES_IDX)) begin
         rules_ff <= csr_pwdata[RULES_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_RULES_IDX) ?
                       {{(CSR_DATA_W-RULES_W){1'b0}}, rules_ff} : '0;

   // advance the chain whenever the result register is free or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      chain_w[0]                  = '0;
      chain_w[0].valid            = req_tvalid;
      chain_w[0].item.cmd         = req_tuser[0];
      chain_w[0].item.fmt         = req_tuser[2:1];
      chain_w[0].item.addr_kind   = req_tuser[4:3];
      chain_w[0].item.word_addr   = req_tdata[6:0];
      chain_w[0].item.word_data   = req_tdata[70:7];
      chain_w[0].item.addr_high   = req_tdata[134:71];
      chain_w[0].item.addr_low    = req_tdata[198:135];
      chain_w[0].item.port        = req_tdata[214:199];
      chain_w[0].item.unit_id     = req_tdata[222:215];
      chain_w[0].item.func_code   = req_tdata[230:223];
      chain_w[0].item.reg_addr    = req_tdata[246:231];
      chain_w[0].item.serial_name = req_tdata[310:247];
   end

   for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
      acl_cell #(
         .INDEX             (g),
         .SERIAL_NAME_BYTES (SERIAL_NAME_BYTES)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .rules_in_use (rules_ff),
         .chain_in     (chain_w[g]),
         .chain_out    (chain_w[g+1])
      );
   end

   assign last = chain_w[MAX_RULES];

   // final verdict
   always_comb begin
      allowed      = 1'b0;
      rule_hit     = 1'b0;
      hit_index    = '0;
      format_error = 1'b0;
      priority if (last.item.cmd == CMD_WRITE) begin
         allowed = 1'b0;
      end else if (rules_ff == '0) begin
         allowed = 1'b1;
      end else if (last.item.fmt != FMT_NET && last.item.fmt != FMT_SERIAL) begin
         format_error = 1'b1;
      end else if (last.hit) begin
         allowed   = 1'b1;
         rule_hit  = 1'b1;
         hit_index = last.hit_idx;
      end else begin
         allowed = !last.applicable;
      end
   end

   assign rsp_data_in = {1'b0, format_error, hit_index, rule_hit, allowed};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/acl_cell.sv =====
// One rule cell: holds the eight words of one rule and checks the passing word.
// Depends on acl_pkg; instanced in a row by request_acl_rule_matcher.
module acl_cell #(
   parameter int INDEX             = 0,
   parameter int SERIAL_NAME_BYTES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [acl_pkg::RULES_W-1:0] rules_in_use,
   input  acl_pkg::chain_type         chain_in,
   output acl_pkg::chain_type         chain_out
);
   import acl_pkg::*;

   localparam bit ONE_BYTE_NAME = (SERIAL_NAME_BYTES < 2);

   logic [WORD_W-1:0] words_ff [WORDS_PER_RULE];
   chain_type         chain_ff;
   chain_type         chain_in_upd;

   logic        wr_here;
   logic        in_range;
   logic        active;
   logic        applies;
   logic        common_ok;
   logic        addr_ok;
   logic        port_ok;
   logic        kind_ok;
   logic [63:0] hi;
   logic [63:0] lo;
   logic        wild;
   logic        mismatch;
   logic        reached;
   logic        rule_ok;
   logic [WORD_W-1:0] w0;
   logic [WORD_W-1:0] w1;
   logic [WORD_W-1:0] w6;

   assign w0 = words_ff[W_FLAGS];
   assign w1 = words_ff[W_REG_RANGE];
   assign w6 = words_ff[W_SERIAL];

   assign wr_here = advance && chain_in.valid && (chain_in.item.cmd == CMD_WRITE) &&
                    (32'(chain_in.item.word_addr[WORD_ADDR_W-1:WORD_SEL_W]) == INDEX);

   always_ff @(posedge clock) begin
      if (wr_here) begin
         words_ff[chain_in.item.word_addr[WORD_SEL_W-1:0]] <= chain_in.item.word_data;
      end
   end

   assign in_range = (32'(rules_in_use) > INDEX);
   assign active   = chain_in.valid && (chain_in.item.cmd == CMD_CHECK) && !chain_in.hit &&
                     in_range &&
                     (chain_in.item.fmt == FMT_NET || chain_in.item.fmt == FMT_SERIAL);
   assign applies  = (chain_in.item.fmt == FMT_NET) ? w0[0] : w0[1];

   assign common_ok = (w0[15:8] == chain_in.item.unit_id) &&
                      (w0[23:16] == chain_in.item.func_code) &&
                      (chain_in.item.reg_addr >= w1[15:0]) &&
                      (chain_in.item.reg_addr <= w1[31:16]);

   // map IPv4 to ::ffff:a.b.c.d
   always_comb begin
      hi      = chain_in.item.addr_high;
      lo      = chain_in.item.addr_low;
      kind_ok = 1'b0;
      unique case (chain_in.item.addr_kind)
         ADDR_V4: begin
            hi      = '0;
            lo      = {V4_MAP_UPPER, chain_in.item.addr_low[31:0]};
            kind_ok = 1'b1;
         end
         ADDR_V6: begin
            kind_ok = 1'b1;
         end
         default: begin
            kind_ok = 1'b0;
         end
      endcase
   end

   assign addr_ok = !w0[2] ||
                    (kind_ok && (((hi ^ words_ff[W_ADDR_HI]) & words_ff[W_MASK_HI]) == '0) &&
                     (((lo ^ words_ff[W_ADDR_LO]) & words_ff[W_MASK_LO]) == '0));
   assign port_ok = !w0[3] ||
                    ((chain_in.item.port >= w0[47:32]) && (chain_in.item.port <= w0[63:48]));

   assign wild = (w6[7:0] == 8'h00) ||
                 ((w6[7:0] == ASTERISK) && (ONE_BYTE_NAME || (w6[15:8] == 8'h00)));

   // compare bytes up to and including the first zero byte of the rule's id
   always_comb begin
      mismatch = 1'b0;
      reached  = 1'b1;
      for (int i = 0; i < SERIAL_NAME_BYTES; i++) begin
         if (reached && (w6[8*i +: 8] != chain_in.item.serial_name[8*i +: 8])) begin
            mismatch = 1'b1;
         end
         reached = reached && (w6[8*i +: 8] != 8'h00);
      end
   end

   assign rule_ok = (chain_in.item.fmt == FMT_NET) ? (addr_ok && port_ok && common_ok)
                                                   : ((wild || !mismatch) && common_ok);

   always_comb begin
      chain_in_upd = chain_in;
      if (active && applies) begin
         chain_in_upd.applicable = 1'b1;
         if (rule_ok) begin
            chain_in_upd.hit     = 1'b1;
            chain_in_upd.hit_idx = HIT_IDX_W'(INDEX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff.valid <= 1'b0;
      end else if (advance) begin
         chain_ff <= chain_in_upd;
      end
   end

   assign chain_out = chain_ff;

endmodule

// ===== rtl/acl_chk.sv =====
// Port checker for request_acl_rule_matcher, attached by the bind below.
// Depends on acl_pkg for the stream widths.
module acl_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [acl_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import acl_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   a_hit_allows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0] && !rsp_tdata[6])
      else $error("rule hit without allow");

   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[5:2] == '0 &&
                                       !(rsp_tdata[6] && rsp_tdata[0]))
      else $error("hit index or format error inconsistent");

endmodule

bind request_acl_rule_matcher acl_chk u_acl_chk (.*);
